[design/rgbahd_pkg.sv]
package rgbahd_pkg;

   // position and statistic widths
   localparam int unsigned PosWidth   = 12;
   localparam int unsigned CountWidth = 25;
   localparam int unsigned CfgWidth   = 13;
   localparam int unsigned MaxWidth   = 4096;

   // saturation value of the pixel counters
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(25'd16777216);

   // luma weights
   localparam logic [7:0] LumaRed   = 8'd77;
   localparam logic [7:0] LumaGreen = 8'd150;
   localparam logic [7:0] LumaBlue  = 8'd29;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH = 1'b0,
      CSR_TOLERANCE   = 1'b1
   } csr_index_type;

   // input item: pixel of image a and of image b
   typedef struct packed {
      logic [7:0] a_red;
      logic [7:0] a_green;
      logic [7:0] a_blue;
      logic [7:0] a_alpha;
      logic [7:0] b_red;
      logic [7:0] b_green;
      logic [7:0] b_blue;
      logic [7:0] b_alpha;
      logic       first_pixel;
   } req_data_type;

   // result item: heat-map pixel and running statistics
   typedef struct packed {
      logic [7:0]            heat_red;
      logic [7:0]            heat_green;
      logic [7:0]            heat_blue;
      logic [7:0]            max_diff;
      logic [PosWidth-1:0]   worst_column;
      logic [PosWidth-1:0]   worst_row;
      logic [CountWidth-1:0] any_diff_count;
      logic [CountWidth-1:0] over_tolerance_count;
   } rsp_data_type;

   // per-pixel result of the difference logic
   typedef struct packed {
      logic [7:0] diff;
      logic [7:0] heat_red;
      logic [7:0] heat_green;
      logic [7:0] heat_blue;
   } pixel_type;

   // running statistics including the current pixel
   typedef struct packed {
      logic [7:0]            max_diff;
      logic [PosWidth-1:0]   worst_column;
      logic [PosWidth-1:0]   worst_row;
      logic [CountWidth-1:0] any_diff_count;
      logic [CountWidth-1:0] over_tolerance_count;
   } stats_type;

endpackage

[design/rgbahd_diff.sv]
module rgbahd_diff
   import rgbahd_pkg::*;
(
   input  req_data_type pix_data,
   output pixel_type    pix_result
);

   logic [7:0]  diff_red;
   logic [7:0]  diff_green;
   logic [7:0]  diff_blue;
   logic [7:0]  diff_alpha;
   logic [7:0]  max_rg;
   logic [7:0]  max_ba;
   logic [7:0]  diff;
   logic [15:0] luma_sum;
   logic [7:0]  grey;

   // absolute channel differences
   always_comb begin
      diff_red   = (pix_data.a_red > pix_data.b_red) ? pix_data.a_red - pix_data.b_red
                                                     : pix_data.b_red - pix_data.a_red;
      diff_green = (pix_data.a_green > pix_data.b_green) ?
                   pix_data.a_green - pix_data.b_green : pix_data.b_green - pix_data.a_green;
      diff_blue  = (pix_data.a_blue > pix_data.b_blue) ?
                   pix_data.a_blue - pix_data.b_blue : pix_data.b_blue - pix_data.a_blue;
      diff_alpha = (pix_data.a_alpha > pix_data.b_alpha) ?
                   pix_data.a_alpha - pix_data.b_alpha : pix_data.b_alpha - pix_data.a_alpha;
   end

   // largest channel difference, two-level compare tree
   always_comb begin
      max_rg = (diff_red > diff_green) ? diff_red : diff_green;
      max_ba = (diff_blue > diff_alpha) ? diff_blue : diff_alpha;
      diff   = (max_rg > max_ba) ? max_rg : max_ba;
   end

   // luma of image a; weights sum to 256 so the total fits 16 bits
   always_comb begin
      luma_sum = 16'(LumaRed * pix_data.a_red)
               + 16'(LumaGreen * pix_data.a_green)
               + 16'(LumaBlue * pix_data.a_blue);
      // luma then quartered
      grey = {2'b00, luma_sum[15:10]};
   end

   // heat colour
   always_comb begin
      pix_result.diff = diff;
      if (diff != 8'd0) begin
         pix_result.heat_red   = 8'd255;
         pix_result.heat_green = (diff >= 8'd32) ? 8'd0 : 8'd255 - {diff[4:0], 3'b000};
         pix_result.heat_blue  = 8'd0;
      end else begin
         pix_result.heat_red   = grey;
         pix_result.heat_green = grey;
         pix_result.heat_blue  = grey;
      end
   end

endmodule

[design/rgbahd_stats.sv]
module rgbahd_stats
   import rgbahd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                first_pixel,
   input  logic [7:0]          diff,
   input  logic [CfgWidth-1:0] image_width,
   input  logic [7:0]          tolerance,
   output stats_type           stats
);

   logic [PosWidth-1:0]   column_ff, column_in;
   logic [PosWidth-1:0]   row_ff, row_in;
   logic [7:0]            max_diff_ff;
   logic [PosWidth-1:0]   worst_column_ff;
   logic [PosWidth-1:0]   worst_row_ff;
   logic [CountWidth-1:0] any_count_ff;
   logic [CountWidth-1:0] over_count_ff;

   logic [PosWidth-1:0]   column_cur;
   logic [PosWidth-1:0]   row_cur;
   stats_type             stats_cur;
   logic [CfgWidth-1:0]   width_eff;
   logic [CfgWidth-1:0]   column_next;

   // state as seen by this pixel, cleared by the first-pixel mark
   always_comb begin
      if (first_pixel) begin
         column_cur = '0;
         row_cur    = '0;
         stats_cur  = '0;
      end else begin
         column_cur                     = column_ff;
         row_cur                        = row_ff;
         stats_cur.max_diff             = max_diff_ff;
         stats_cur.worst_column         = worst_column_ff;
         stats_cur.worst_row            = worst_row_ff;
         stats_cur.any_diff_count       = any_count_ff;
         stats_cur.over_tolerance_count = over_count_ff;
      end
   end

   // statistics including this pixel
   always_comb begin
      stats = stats_cur;
      if (diff > stats_cur.max_diff) begin
         stats.max_diff     = diff;
         stats.worst_column = column_cur;
         stats.worst_row    = row_cur;
      end
      if (diff != 8'd0 && stats_cur.any_diff_count < CountLimit) begin
         stats.any_diff_count = stats_cur.any_diff_count + CountWidth'(1);
      end
      if (diff > tolerance && stats_cur.over_tolerance_count < CountLimit) begin
         stats.over_tolerance_count = stats_cur.over_tolerance_count + CountWidth'(1);
      end
   end

   // raster position of the next pixel; row wraps naturally at 4096
   always_comb begin
      if (image_width == '0) begin
         width_eff = CfgWidth'(1);
      end else if (image_width > CfgWidth'(MaxWidth)) begin
         width_eff = CfgWidth'(MaxWidth);
      end else begin
         width_eff = image_width;
      end
      column_next = {1'b0, column_cur} + CfgWidth'(1);
      if (column_next >= width_eff) begin
         column_in = '0;
         row_in    = row_cur + PosWidth'(1);
      end else begin
         column_in = column_next[PosWidth-1:0];
         row_in    = row_cur;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         row_ff          <= '0;
         max_diff_ff     <= '0;
         worst_column_ff <= '0;
         worst_row_ff    <= '0;
         any_count_ff    <= '0;
         over_count_ff   <= '0;
      end else if (step) begin
         column_ff       <= column_in;
         row_ff          <= row_in;
         max_diff_ff     <= stats.max_diff;
         worst_column_ff <= stats.worst_column;
         worst_row_ff    <= stats.worst_row;
         any_count_ff    <= stats.any_diff_count;
         over_count_ff   <= stats.over_tolerance_count;
      end
   end

endmodule

[design/rgba_image_diff_heatmap.sv]
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_data (pixel pair, first-pixel mark)
// rsp       out        rsp_valid/rsp_stall  rsp_data (heat pixel, running statistics)
// csr       in         csr_write            csr_index, csr_data
//
// one item per cycle sustained while rsp_stall is low; an accepted item passes the
// input register and then the result register before rsp valid, and the difference
// and statistics logic between the two registers is combinational
// synchronous active-high reset clears statistics, position and both item stages
// req_stall rises only when the input register is full and the result is stalled
module rgba_image_diff_heatmap
   import rgbahd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_data_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_data_type        rsp_data,
   input  logic                csr_write,
   input  csr_index_type       csr_index,
   input  logic [CfgWidth-1:0] csr_data
);

   logic                in_valid_ff, in_valid_in;
   req_data_type        in_data_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_data_type        out_data_ff, out_data_in;
   logic [CfgWidth-1:0] image_width_ff;
   logic [7:0]          tolerance_ff;

   logic      req_accept;
   logic      advance;
   pixel_type pix_result;
   stats_type stats;

   // handshake between the two stages
   always_comb begin
      advance     = in_valid_ff && !(out_valid_ff && rsp_stall);
      req_stall   = in_valid_ff && !advance;
      req_accept  = req_valid && !req_stall;
      in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= CfgWidth'(1);
         tolerance_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: image_width_ff <= csr_data;
            CSR_TOLERANCE:   tolerance_ff   <= csr_data[7:0];
            default:         tolerance_ff   <= tolerance_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
   end

   // per-pixel difference and heat colour
   rgbahd_diff u_diff (
      .pix_data   (in_data_ff),
      .pix_result (pix_result)
   );

   // running statistics and raster position
   rgbahd_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .first_pixel (in_data_ff.first_pixel),
      .diff        (pix_result.diff),
      .image_width (image_width_ff),
      .tolerance   (tolerance_ff),
      .stats       (stats)
   );

   // result register
   always_comb begin
      out_data_in.heat_red             = pix_result.heat_red;
      out_data_in.heat_green           = pix_result.heat_green;
      out_data_in.heat_blue            = pix_result.heat_blue;
      out_data_in.max_diff             = stats.max_diff;
      out_data_in.worst_column         = stats.worst_column;
      out_data_in.worst_row            = stats.worst_row;
      out_data_in.any_diff_count       = stats.any_diff_count;
      out_data_in.over_tolerance_count = stats.over_tolerance_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // stall only when an item is held in the input register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall without a held item");

   // a first pixel always reports the origin and at most one differing pixel
   a_first_pixel_origin: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.first_pixel) |=>
         (rsp_data.worst_column == '0 && rsp_data.worst_row == '0 &&
          rsp_data.any_diff_count <= CountWidth'(1)))
      else $error("first pixel did not clear statistics");

   // every over-tolerance pixel is also a differing pixel
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.over_tolerance_count <= rsp_data.any_diff_count))
      else $error("over-tolerance count exceeds differing count");

endmodule

[tb/sv/rgba_image_diff_heatmap_test.sv]
module rgba_image_diff_heatmap_test;
   import rgbahd_pkg::*;

   localparam int unsigned RowLimit   = 4096;
   localparam int unsigned HoldCycles = 120;
   localparam int unsigned QuietLimit = 2000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_data_type        req_data    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_data_type        rsp_data;
   logic                csr_write   = 1'b0;
   csr_index_type       csr_index   = CSR_IMAGE_WIDTH;
   logic [CfgWidth-1:0] csr_data    = '0;

   // pixel pairs waiting to be offered, heat results waiting to arrive
   req_data_type pixel_queue[$];
   rsp_data_type heat_expect_q[$];

   // tracking copy of the block's state and registers
   logic [CfgWidth-1:0]   cfg_width;
   logic [7:0]            cfg_tolerance;
   int unsigned           track_col;
   int unsigned           track_row;
   logic [7:0]            peak_diff;
   logic [PosWidth-1:0]   peak_col;
   logic [PosWidth-1:0]   peak_row;
   logic [CountWidth-1:0] diff_total;
   logic [CountWidth-1:0] over_total;

   logic        req_fire = 1'b0;
   int unsigned error_count  = 0;
   int unsigned item_count   = 0;
   int unsigned result_count = 0;
   int unsigned csr_count    = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_off_id  = 0;

   rgba_image_diff_heatmap dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock and reset
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // heat pixel and running statistics for one pixel pair, advancing the tracked state
   function automatic rsp_data_type predict_heat(req_data_type px);
      rsp_data_type res;
      int unsigned  d;
      int unsigned  c;
      int unsigned  luma;
      int unsigned  w;
      logic [7:0]   a_ch[4];
      logic [7:0]   b_ch[4];
      a_ch = '{px.a_red, px.a_green, px.a_blue, px.a_alpha};
      b_ch = '{px.b_red, px.b_green, px.b_blue, px.b_alpha};
      if (px.first_pixel) begin
         track_col  = 0;
         track_row  = 0;
         peak_diff  = '0;
         peak_col   = '0;
         peak_row   = '0;
         diff_total = '0;
         over_total = '0;
      end
      d = 0;
      for (int k = 0; k < 4; k++) begin
         c = (a_ch[k] > b_ch[k]) ? a_ch[k] - b_ch[k] : b_ch[k] - a_ch[k];
         if (c > d) d = c;
      end
      // strictly greater moves the worst position, ties do not
      if (d > peak_diff) begin
         peak_diff = d[7:0];
         peak_col  = track_col[PosWidth-1:0];
         peak_row  = track_row[PosWidth-1:0];
      end
      if (d > 0) diff_total = (diff_total < CountLimit) ? diff_total + 1'b1 : CountLimit;
      if (d > cfg_tolerance) over_total = (over_total < CountLimit) ? over_total + 1'b1 : CountLimit;
      if (d > 0) begin
         res.heat_red   = 8'd255;
         res.heat_green = (d >= 32) ? 8'd0 : 8'(255 - 8 * d);
         res.heat_blue  = 8'd0;
      end else begin
         luma = (77 * px.a_red + 150 * px.a_green + 29 * px.a_blue) >> 8;
         res.heat_red   = 8'(luma / 4);
         res.heat_green = 8'(luma / 4);
         res.heat_blue  = 8'(luma / 4);
      end
      // raster position, width zero counts as one, wide rows wrap at the maximum
      w = (cfg_width == 0) ? 1 : cfg_width;
      if (w > MaxWidth) w = MaxWidth;
      if (track_col + 1 >= w) begin
         track_col = 0;
         track_row = (track_row + 1 >= RowLimit) ? 0 : track_row + 1;
      end else begin
         track_col = track_col + 1;
      end
      res.max_diff             = peak_diff;
      res.worst_column         = peak_col;
      res.worst_row            = peak_row;
      res.any_diff_count       = diff_total;
      res.over_tolerance_count = over_total;
      return res;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // monitor: register writes, input items and results, all seen at the rising edge
   always @(posedge clock) begin : heat_monitor
      rsp_data_type want;
      req_fire <= req_valid && !req_stall;
      if (reset) begin
         cfg_width     = 13'd1;
         cfg_tolerance = 8'd0;
         track_col     = 0;
         track_row     = 0;
         peak_diff     = '0;
         peak_col      = '0;
         peak_row      = '0;
         diff_total    = '0;
         over_total    = '0;
      end else begin
         if (csr_write) begin
            csr_count++;
            case (csr_index)
               CSR_IMAGE_WIDTH: cfg_width = csr_data;
               CSR_TOLERANCE:   cfg_tolerance = csr_data[7:0];
               default:         ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (heat_expect_q.size() == 0) begin
               $error("heat result with no pixel item outstanding");
               error_count++;
            end else begin
               want = heat_expect_q.pop_front();
               check_field("heat_red", want.heat_red, rsp_data.heat_red);
               check_field("heat_green", want.heat_green, rsp_data.heat_green);
               check_field("heat_blue", want.heat_blue, rsp_data.heat_blue);
               check_field("max_diff", want.max_diff, rsp_data.max_diff);
               check_field("worst_column", want.worst_column, rsp_data.worst_column);
               check_field("worst_row", want.worst_row, rsp_data.worst_row);
               check_field("any_diff_count", want.any_diff_count, rsp_data.any_diff_count);
               check_field("over_tolerance_count", want.over_tolerance_count,
                           rsp_data.over_tolerance_count);
            end
         end
         if (req_valid && !req_stall) begin
            item_count++;
            heat_expect_q.push_back(predict_heat(req_data));
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin : quiet_watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $error("no item moved for %0d cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end
   end

   // driver: bursts of pixel items with random gaps
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin : pixel_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            req_data  <= pixel_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned stall_tick = 0;
   int unsigned hold_left  = 0;
   int unsigned hold_seen  = 0;

   always @(negedge clock) begin : result_staller
      logic next_stall;
      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (hold_seen != hold_off_id) begin
         hold_seen  = hold_off_id;
         hold_left  = HoldCycles - 1;
         next_stall = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 300);
         end
         mode_left--;
         case (stall_mode)
            0:       next_stall = 1'b0;
            1:       next_stall = 1'($urandom_range(0, 1));
            2:       next_stall = (stall_tick % 7) < 3;
            default: next_stall = ($urandom_range(0, 4) != 0);
         endcase
      end
      rsp_stall <= next_stall;
   end

   // stimulus helpers
   task automatic write_reg(csr_index_type idx, logic [CfgWidth-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_valid || heat_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_data_type pixel(logic [31:0] a, logic [31:0] b, logic mark);
      return req_data_type'({a, b, mark});
   endfunction

   function automatic logic [7:0] nudge(logic [7:0] v, int spread);
      int r;
      r = int'($urandom_range(0, 2 * spread)) - spread + int'(v);
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return r[7:0];
   endfunction

   // random pixel pair: b independent of a when spread is negative, else near a
   function automatic req_data_type pixel_pair(int spread, logic mark);
      req_data_type px;
      px = pixel(32'($urandom()), 32'($urandom()), mark);
      if (spread >= 0) begin
         px.b_red   = nudge(px.a_red, spread);
         px.b_green = nudge(px.a_green, spread);
         px.b_blue  = nudge(px.a_blue, spread);
         px.b_alpha = nudge(px.a_alpha, spread);
      end
      return px;
   endfunction

   // images of whole rows when narrow, else of random length, with a first-pixel mark, plus missing and stray marks
   task automatic queue_images(int unsigned width_code, int unsigned count);
      int unsigned w;
      int unsigned total;
      int unsigned len;
      int unsigned cls;
      int          spread;
      logic        mark;
      int          mix[4];
      mix   = '{1, 8, 40, -1};
      w     = (width_code == 0) ? 1 : ((width_code > MaxWidth) ? MaxWidth : width_code);
      total = 0;
      while (total < count) begin
         len = (w <= 64) ? w * $urandom_range(1, 4) : $urandom_range(1, 200);
         cls = $urandom_range(0, 4);
         for (int i = 0; i < len; i++) begin
            mark = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
            case (cls)
               0:       spread = 0;
               1:       spread = 2;
               2:       spread = 20;
               3:       spread = -1;
               default: spread = mix[$urandom_range(0, 3)];
            endcase
            if ($urandom_range(0, 3) == 0) spread = 0;
            pixel_queue.push_back(pixel_pair(spread, mark));
         end
         total += len;
      end
   endtask

   // one image whose difference climbs slowly, so the worst position keeps moving
   task automatic queue_ramp(int unsigned count);
      req_data_type px;
      int unsigned  d;
      for (int unsigned i = 0; i < count; i++) begin
         d  = i / 4;
         px = pixel_pair(0, i == 0);
         px.b_red = (px.a_red >= d) ? px.a_red - d[7:0] : px.a_red + d[7:0];
         pixel_queue.push_back(px);
      end
   endtask

   // stimulus sequence
   int unsigned phase_width[10] = '{5, 1, 16, 4096, 8191, 640, 0, 4097, 33, 2};
   int unsigned phase_tol[10]   = '{0, 255, 30, 7, 128, 3, 1, 64, 255, 0};

   initial begin
      @(negedge reset);
      @(negedge clock);

      // reset registers, no first-pixel mark yet
      pixel_queue.push_back(pixel(32'h0000_0000, 32'h0000_0000, 1'b0));
      pixel_queue.push_back(pixel(32'hffff_ffff, 32'hffff_ffff, 1'b0));
      pixel_queue.push_back(pixel(32'hff00_00ff, 32'h00ff_ff00, 1'b0));
      wait_drained();

      // narrow rows, tolerance edge, ties, green ramp edge, mark mid-stream
      write_reg(CSR_IMAGE_WIDTH, 13'd3);
      write_reg(CSR_TOLERANCE, 13'd10);
      pixel_queue.push_back(pixel(32'h1020_3040, 32'h1020_3040, 1'b1));
      pixel_queue.push_back(pixel(32'h1020_3040, 32'h1020_3041, 1'b0));
      pixel_queue.push_back(pixel(32'h8080_8080, 32'h6180_8080, 1'b0));
      pixel_queue.push_back(pixel(32'h8080_8080, 32'h8080_6080, 1'b0));
      pixel_queue.push_back(pixel(32'h8080_8080, 32'h80a0_8080, 1'b0));
      pixel_queue.push_back(pixel(32'h8080_8080, 32'h8a80_8080, 1'b0));
      pixel_queue.push_back(pixel(32'h8080_8080, 32'h808b_8080, 1'b0));
      pixel_queue.push_back(pixel(32'h4444_4444, 32'h4444_4949, 1'b1));
      pixel_queue.push_back(pixel(32'h7f7f_7f7f, 32'h7f7f_7f7f, 1'b0));
      pixel_queue.push_back(pixel(32'h0000_0000, 32'h0000_00ff, 1'b0));
      pixel_queue.push_back(pixel(32'h00ff_00ff, 32'hff00_ff00, 1'b0));
      wait_drained();

      // width zero behaves as one pixel per row, top tolerance
      write_reg(CSR_IMAGE_WIDTH, 13'd0);
      write_reg(CSR_TOLERANCE, 13'd255);
      pixel_queue.push_back(pixel(32'h0102_0304, 32'h0102_0304, 1'b1));
      pixel_queue.push_back(pixel(32'h0102_0304, 32'h0202_0304, 1'b0));
      pixel_queue.push_back(pixel(32'h0102_0304, 32'h0104_0304, 1'b0));
      pixel_queue.push_back(pixel(32'h0102_0304, 32'h0102_0307, 1'b0));
      pixel_queue.push_back(pixel(32'hffff_ffff, 32'h0000_0000, 1'b0));
      wait_drained();

      // random images over a range of settings
      for (int p = 0; p < 10; p++) begin
         write_reg(CSR_IMAGE_WIDTH, phase_width[p][CfgWidth-1:0]);
         write_reg(CSR_TOLERANCE, phase_tol[p][CfgWidth-1:0]);
         queue_images(phase_width[p], 120);
         if (p == 2 || p == 7) hold_off_id++;
         wait_drained();
      end

      // climbing difference on one-pixel rows under a long hold-off
      write_reg(CSR_IMAGE_WIDTH, 13'd1);
      write_reg(CSR_TOLERANCE, 13'd0);
      queue_ramp(100);
      hold_off_id++;
      wait_drained();

      // climbing difference with a width beyond the maximum
      write_reg(CSR_IMAGE_WIDTH, 13'd8191);
      write_reg(CSR_TOLERANCE, 13'd100);
      queue_ramp(100);
      wait_drained();

      if (heat_expect_q.size() != 0) begin
         $error("%0d heat results never arrived", heat_expect_q.size());
         error_count++;
      end
      $display("run covered %0d pixel items and %0d heat results over %0d register writes",
               item_count, result_count, csr_count);
      $display("widths 0 to 8191, tolerances 0 to 255, first-pixel marks, stalls and hold-offs");
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
